[design/tpat_pkg.sv]
// Shared types, constants and helpers of the triac phase-angle trigger.
package tpat_pkg;

   localparam int ANGLE_W  = 8;
   localparam int PERIOD_W = 20;
   localparam int PULSE_W  = 16;
   localparam int OPTO_W   = 16;
   localparam int THRESH_W = 20;
   localparam int TIME_WIDTH = 21;

   // (180 - angle) * period needs 28 bits; the quotient by 360 fits in the period width.
   localparam int PROD_W  = 28;
   localparam int DELAY_W = 20;
   localparam int HALF_W  = PERIOD_W - 1;
   localparam int SUM_W   = 22;

   // x / 360 is computed as (x / 8) / 45, the latter as a multiply by a rounded-up
   // reciprocal. It is exact for every dividend below 2^25.
   localparam int DIV_SHIFT   = 3;
   localparam int RECIP_W     = 26;
   localparam int RECIP_SHIFT = 31;
   localparam int QPROD_W     = PROD_W - DIV_SHIFT + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_45 = 26'd47721859;

   localparam logic [ANGLE_W-1:0]    ANGLE_MAX = 8'd180;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX  = '1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_POS_ANGLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEG_ANGLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPTO_DELAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THRESH = 3'd5;

   typedef struct packed {
      logic                zero_cross;
      logic [PERIOD_W-1:0] mains_period;
   } req_type;

   typedef struct packed {
      logic gate;
      logic triggers_pending;
   } rsp_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]  positive_angle;
      logic [ANGLE_W-1:0]  negative_angle;
      logic [OPTO_W-1:0]   opto_delay;
      logic [PULSE_W-1:0]  long_pulse_ticks;
      logic [PULSE_W-1:0]  short_pulse_ticks;
      logic [THRESH_W-1:0] long_pulse_threshold;
   } cfg_type;

   typedef enum logic [1:0] {
      MODE_OFF,
      MODE_FULL,
      MODE_SCHED
   } mode_type;

   // Schedule computed for one tick, handed to the trigger state stage.
   typedef struct packed {
      logic                  zero_cross;
      mode_type              mode;
      logic                  n_arm;
      logic [TIME_WIDTH-1:0] n_time;
      logic [PULSE_W-1:0]    n_width;
      logic                  p_arm;
      logic [TIME_WIDTH-1:0] p_time;
      logic [PULSE_W-1:0]    p_width;
   } sched_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } pipe_ctl_type;

   function automatic logic [ANGLE_W-1:0] clamp_angle(logic [ANGLE_W-1:0] a);
      return (a > ANGLE_MAX) ? ANGLE_MAX : a;
   endfunction

   function automatic logic time_fits(logic [SUM_W-1:0] s);
      return (TIME_WIDTH >= SUM_W) || ((s >> TIME_WIDTH) == '0);
   endfunction

endpackage

[design/tpat_delay_calc.sv]
// Three-stage datapath that turns a crossing tick into a pulse schedule.
module tpat_delay_calc (
   input  logic                  clock,
   input  tpat_pkg::pipe_ctl_type ctl,
   input  tpat_pkg::cfg_type     cfg,
   input  tpat_pkg::req_type     s0,
   output tpat_pkg::sched_type   sched
);
   import tpat_pkg::*;

   logic [ANGLE_W-1:0]  pa_c;
   logic [ANGLE_W-1:0]  na_c;
   logic [ANGLE_W-1:0]  kp;
   logic [ANGLE_W-1:0]  kn;

   logic                s1_zc_ff;
   logic [PROD_W-1:0]   s1_n_prod_ff;
   logic [PROD_W-1:0]   s1_p_prod_ff;
   logic [HALF_W-1:0]   s1_half_ff;

   logic [QPROD_W-1:0]  n_quot_full;
   logic [QPROD_W-1:0]  p_quot_full;
   logic                s2_zc_ff;
   logic [DELAY_W-1:0]  s2_nd_ff;
   logic [DELAY_W-1:0]  s2_pd_ff;
   logic [HALF_W-1:0]   s2_half_ff;

   logic [DELAY_W-1:0]  nd;
   logic [DELAY_W-1:0]  pd;
   logic [SUM_W-1:0]    n_sum;
   logic [SUM_W-1:0]    p_sum;
   sched_type           sched_in;
   sched_type           sched_ff;

   assign pa_c = clamp_angle(cfg.positive_angle);
   assign na_c = clamp_angle(cfg.negative_angle);
   assign kp   = ANGLE_MAX - pa_c;
   assign kn   = ANGLE_MAX - na_c;

   assign n_quot_full = QPROD_W'(s1_n_prod_ff[PROD_W-1:DIV_SHIFT]) * QPROD_W'(RECIP_45);
   assign p_quot_full = QPROD_W'(s1_p_prod_ff[PROD_W-1:DIV_SHIFT]) * QPROD_W'(RECIP_45);

   // An angle of zero means no delay, so that half is skipped.
   assign nd    = (na_c == '0) ? '0 : s2_nd_ff;
   assign pd    = (pa_c == '0) ? '0 : s2_pd_ff;
   assign n_sum = SUM_W'(cfg.opto_delay) + SUM_W'(nd);
   assign p_sum = SUM_W'(cfg.opto_delay) + SUM_W'(pd) + SUM_W'(s2_half_ff);

   always_comb begin
      sched_in.zero_cross = s2_zc_ff;
      if (pa_c == '0 && na_c == '0) begin
         sched_in.mode = MODE_OFF;
      end else if (pa_c == ANGLE_MAX && na_c == ANGLE_MAX) begin
         sched_in.mode = MODE_FULL;
      end else begin
         sched_in.mode = MODE_SCHED;
      end
      sched_in.n_arm   = (sched_in.mode == MODE_SCHED) && (nd != '0) && time_fits(n_sum);
      sched_in.p_arm   = (sched_in.mode == MODE_SCHED) && (pd != '0) && time_fits(p_sum);
      sched_in.n_time  = TIME_WIDTH'(n_sum);
      sched_in.p_time  = TIME_WIDTH'(p_sum);
      sched_in.n_width = (nd < cfg.long_pulse_threshold) ? cfg.long_pulse_ticks
                                                          : cfg.short_pulse_ticks;
      sched_in.p_width = (pd < cfg.long_pulse_threshold) ? cfg.long_pulse_ticks
                                                          : cfg.short_pulse_ticks;
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         s1_zc_ff     <= s0.zero_cross;
         s1_n_prod_ff <= PROD_W'(kn) * PROD_W'(s0.mains_period);
         s1_p_prod_ff <= PROD_W'(kp) * PROD_W'(s0.mains_period);
         s1_half_ff   <= s0.mains_period[PERIOD_W-1:1];
      end
      if (ctl.en2) begin
         s2_zc_ff   <= s1_zc_ff;
         s2_nd_ff   <= n_quot_full[RECIP_SHIFT +: DELAY_W];
         s2_pd_ff   <= p_quot_full[RECIP_SHIFT +: DELAY_W];
         s2_half_ff <= s1_half_ff;
      end
      if (ctl.en3) begin
         sched_ff <= sched_in;
      end
   end

   assign sched = sched_ff;

endmodule

[design/tpat_fire_ctrl.sv]
// Trigger state: tick counter, armed pulses and the gate pulse timer.
module tpat_fire_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                upd,
   input  tpat_pkg::sched_type sched,
   output tpat_pkg::rsp_type   rsp
);
   import tpat_pkg::*;

   logic [TIME_WIDTH-1:0] tss_ff, tss_in;
   logic [TIME_WIDTH-1:0] nft_ff, nft_in;
   logic [TIME_WIDTH-1:0] pft_ff, pft_in;
   logic                  narm_ff, narm_in;
   logic                  parm_ff, parm_in;
   logic [PULSE_W-1:0]    nw_ff, nw_in;
   logic [PULSE_W-1:0]    pw_ff, pw_in;
   logic [PULSE_W-1:0]    pr_ff, pr_in;
   logic                  gate_ff, gate_in;
   logic                  n_start;
   logic                  p_start;

   always_comb begin
      tss_in  = tss_ff;
      nft_in  = nft_ff;
      pft_in  = pft_ff;
      narm_in = narm_ff;
      parm_in = parm_ff;
      nw_in   = nw_ff;
      pw_in   = pw_ff;
      pr_in   = pr_ff;
      gate_in = gate_ff;
      n_start = 1'b0;
      p_start = 1'b0;
      if (sched.zero_cross) begin
         // A crossing cancels everything pending and restarts the count.
         tss_in  = '0;
         pr_in   = '0;
         narm_in = sched.n_arm;
         parm_in = sched.p_arm;
         nft_in  = sched.n_time;
         pft_in  = sched.p_time;
         nw_in   = sched.n_width;
         pw_in   = sched.p_width;
         unique case (sched.mode)
            MODE_OFF:   gate_in = 1'b0;
            MODE_FULL:  gate_in = 1'b1;
            MODE_SCHED: gate_in = 1'b0;
            default:    gate_in = 1'b0;
         endcase
      end else begin
         if (tss_ff != TIME_MAX) begin
            tss_in = tss_ff + TIME_WIDTH'(1);
         end
         if (pr_ff != '0) begin
            pr_in = pr_ff - PULSE_W'(1);
            if (pr_in == '0) begin
               gate_in = 1'b0;
            end
         end
         // The negative pulse has priority; a late pulse starts once the other ends.
         if (pr_in == '0) begin
            if (narm_ff && tss_in >= nft_ff) begin
               n_start = 1'b1;
            end else if (parm_ff && !narm_ff && tss_in >= pft_ff) begin
               p_start = 1'b1;
            end
         end
         if (n_start) begin
            narm_in = 1'b0;
            pr_in   = nw_ff;
            gate_in = (nw_ff != '0);
         end
         if (p_start) begin
            parm_in = 1'b0;
            pr_in   = pw_ff;
            gate_in = (pw_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tss_ff  <= '0;
         nft_ff  <= '0;
         pft_ff  <= '0;
         narm_ff <= 1'b0;
         parm_ff <= 1'b0;
         nw_ff   <= '0;
         pw_ff   <= '0;
         pr_ff   <= '0;
         gate_ff <= 1'b0;
      end else if (upd) begin
         tss_ff  <= tss_in;
         nft_ff  <= nft_in;
         pft_ff  <= pft_in;
         narm_ff <= narm_in;
         parm_ff <= parm_in;
         nw_ff   <= nw_in;
         pw_ff   <= pw_in;
         pr_ff   <= pr_in;
         gate_ff <= gate_in;
      end
   end

   assign rsp.gate             = gate_ff;
   assign rsp.triggers_pending = narm_ff | parm_ff;

   a_pulse_drives_gate: assert property (@(posedge clock) disable iff (reset)
      pr_ff != '0 |-> gate_ff)
      else $error("pulse timer running with gate low");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      upd && !sched.zero_cross && tss_ff != TIME_MAX
      |=> tss_ff == $past(tss_ff) + TIME_WIDTH'(1))
      else $error("tick counter did not advance");

   a_positive_after_negative: assert property (@(posedge clock) disable iff (reset)
      upd && p_start |-> !narm_ff && !n_start)
      else $error("positive pulse started ahead of negative pulse");

endmodule

[design/triac_phase_angle_trigger.sv]
// Top level of the triac phase-angle trigger: registers, handshake and pipeline.
//
// Each request is one time tick: zero_cross marks a mains crossing and
// mains_period carries the measured period. Every request yields exactly one
// response with the gate level for that tick and whether a trigger of the
// current half-cycle pair is still due.
// A request passes from acceptance to a valid response through five registers:
// an input register, the angle multiply, the divide by 360 (a reciprocal
// multiply), the schedule stage, and the trigger state which is also the
// response register. Throughput is one request per cycle unless rsp_ready
// stalls it; the two multiply stages set the depth.
// Each stage holds its item only while the stage after it is full and
// stalled, so requests keep flowing into empty stages while a response waits.
// Configuration registers are written through csr_we/csr_index/csr_wdata and
// take effect immediately; writes to unknown indexes are ignored.
// Synchronous reset clears the configuration, the valid bits and the trigger
// state, empties the pipeline, drives the gate low and disarms both triggers.
module triac_phase_angle_trigger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tpat_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tpat_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [tpat_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpat_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tpat_pkg::*;

   cfg_type      cfg_ff;
   req_type      s0_ff;
   logic         v0_ff, v1_ff, v2_ff, v3_ff, out_v_ff;
   logic         rdy0, rdy1, rdy2, rdy3, adv_out;
   logic         upd;
   pipe_ctl_type ctl;
   sched_type    sched;

   assign adv_out = !out_v_ff || rsp_ready;
   assign rdy3    = !v3_ff || adv_out;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;
   assign rdy0    = !v0_ff || rdy1;
   assign upd     = v3_ff && adv_out;

   assign ctl.en1 = rdy1;
   assign ctl.en2 = rdy2;
   assign ctl.en3 = rdy3;

   assign req_ready = rdy0;
   assign rsp_valid = out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POS_ANGLE:   cfg_ff.positive_angle       <= csr_wdata[ANGLE_W-1:0];
               CSR_NEG_ANGLE:   cfg_ff.negative_angle       <= csr_wdata[ANGLE_W-1:0];
               CSR_OPTO_DELAY:  cfg_ff.opto_delay           <= csr_wdata[OPTO_W-1:0];
               CSR_LONG_TICKS:  cfg_ff.long_pulse_ticks     <= csr_wdata[PULSE_W-1:0];
               CSR_SHORT_TICKS: cfg_ff.short_pulse_ticks    <= csr_wdata[PULSE_W-1:0];
               CSR_LONG_THRESH: cfg_ff.long_pulse_threshold <= csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         if (rdy0) begin
            v0_ff <= req_valid;
         end
         if (rdy1) begin
            v1_ff <= v0_ff;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (adv_out) begin
            out_v_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         s0_ff <= req_data;
      end
   end

   tpat_delay_calc u_delay_calc (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg_ff),
      .s0    (s0_ff),
      .sched (sched)
   );

   tpat_fire_ctrl u_fire_ctrl (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .sched (sched),
      .rsp   (rsp_data)
   );

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy3 |=> v3_ff)
      else $error("schedule stage lost a request while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v0_ff && !v1_ff && !v2_ff && !v3_ff |-> req_ready)
      else $error("empty pipeline refused a request");

endmodule

[verif/gate_timing_checker.sv]
// Checker for the triac trigger: predicts every gate tick and compares the responses.
module gate_timing_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  tpat_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  tpat_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [tpat_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpat_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  failures,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import tpat_pkg::*;

   localparam longint unsigned DEGREES_PER_PERIOD = 360;
   localparam int REPORT_LIMIT = 10;

   // Shadow of the register file and of the trigger state.
   cfg_type               settings;
   logic [TIME_WIDTH-1:0] since_sync;
   logic [TIME_WIDTH-1:0] neg_due;
   logic [TIME_WIDTH-1:0] pos_due;
   logic                  neg_armed;
   logic                  pos_armed;
   logic [PULSE_W-1:0]    neg_len;
   logic [PULSE_W-1:0]    pos_len;
   logic [PULSE_W-1:0]    pulse_left;
   logic                  gate_q;

   rsp_type gate_forecast[$];
   rsp_type want;

   function automatic longint unsigned half_delay(logic [ANGLE_W-1:0] angle,
                                                  longint unsigned period);
      if (angle == '0) begin
         return 0;
      end
      return (64'(ANGLE_MAX - angle) * period) / DEGREES_PER_PERIOD;
   endfunction

   function automatic logic [PULSE_W-1:0] pulse_for(longint unsigned delay);
      return (delay < 64'(settings.long_pulse_threshold)) ?
             settings.long_pulse_ticks : settings.short_pulse_ticks;
   endfunction

   function automatic rsp_type advance_gate_tick(req_type r);
      logic [ANGLE_W-1:0] pa;
      logic [ANGLE_W-1:0] na;
      longint unsigned    period;
      longint unsigned    nd;
      longint unsigned    pd;
      longint unsigned    nt;
      longint unsigned    pt;
      mode_type           mode;
      rsp_type            result;
      period = 64'(r.mains_period);
      if (r.zero_cross) begin
         pa = (settings.positive_angle > ANGLE_MAX) ? ANGLE_MAX : settings.positive_angle;
         na = (settings.negative_angle > ANGLE_MAX) ? ANGLE_MAX : settings.negative_angle;
         since_sync = '0;
         neg_armed  = 1'b0;
         pos_armed  = 1'b0;
         pulse_left = '0;
         if (pa == '0 && na == '0) begin
            mode = MODE_OFF;
         end else if (pa == ANGLE_MAX && na == ANGLE_MAX) begin
            mode = MODE_FULL;
         end else begin
            mode = MODE_SCHED;
         end
         case (mode)
            MODE_OFF: begin
               gate_q = 1'b0;
            end
            MODE_FULL: begin
               gate_q = 1'b1;
            end
            default: begin
               nd = half_delay(na, period);
               pd = half_delay(pa, period);
               nt = 64'(settings.opto_delay) + nd;
               pt = 64'(settings.opto_delay) + pd + period / 2;
               gate_q = 1'b0;
               // A zero delay skips that half; a time past the counter range never fires.
               if (nd != 0 && nt <= 64'(TIME_MAX)) begin
                  neg_armed = 1'b1;
                  neg_due   = TIME_WIDTH'(nt);
                  neg_len   = pulse_for(nd);
               end
               if (pd != 0 && pt <= 64'(TIME_MAX)) begin
                  pos_armed = 1'b1;
                  pos_due   = TIME_WIDTH'(pt);
                  pos_len   = pulse_for(pd);
               end
            end
         endcase
      end else begin
         if (since_sync < TIME_MAX) begin
            since_sync = since_sync + 1'b1;
         end
         if (pulse_left != '0) begin
            pulse_left = pulse_left - 1'b1;
            if (pulse_left == '0) begin
               gate_q = 1'b0;
            end
         end
         // The negative half has priority, so a late positive pulse waits for it.
         if (pulse_left == '0) begin
            if (neg_armed && since_sync >= neg_due) begin
               neg_armed  = 1'b0;
               pulse_left = neg_len;
               gate_q     = (neg_len != '0);
            end else if (pos_armed && !neg_armed && since_sync >= pos_due) begin
               pos_armed  = 1'b0;
               pulse_left = pos_len;
               gate_q     = (pos_len != '0);
            end
         end
      end
      result.gate             = gate_q;
      result.triggers_pending = neg_armed | pos_armed;
      return result;
   endfunction

   task automatic note_failure(input string what);
      if (failures < REPORT_LIMIT) begin
         $display("[%0t] gate tick check: %s", $realtime, what);
      end
      failures = failures + 1;
   endtask

   initial begin
      failures = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         settings   = '0;
         since_sync = '0;
         neg_due    = '0;
         pos_due    = '0;
         neg_armed  = 1'b0;
         pos_armed  = 1'b0;
         neg_len    = '0;
         pos_len    = '0;
         pulse_left = '0;
         gate_q     = 1'b0;
         gate_forecast.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_POS_ANGLE:   settings.positive_angle       = csr_wdata[ANGLE_W-1:0];
               CSR_NEG_ANGLE:   settings.negative_angle       = csr_wdata[ANGLE_W-1:0];
               CSR_OPTO_DELAY:  settings.opto_delay           = csr_wdata[OPTO_W-1:0];
               CSR_LONG_TICKS:  settings.long_pulse_ticks     = csr_wdata[PULSE_W-1:0];
               CSR_SHORT_TICKS: settings.short_pulse_ticks    = csr_wdata[PULSE_W-1:0];
               CSR_LONG_THRESH: settings.long_pulse_threshold = csr_wdata[THRESH_W-1:0];
               default: ;
            endcase
         end
         // Responses are matched before new requests are queued, since no
         // response can belong to a request accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (gate_forecast.size() == 0) begin
               note_failure($sformatf("response gate=%b pending=%b with no request waiting",
                                      rsp_data.gate, rsp_data.triggers_pending));
            end else begin
               want = gate_forecast.pop_front();
               if (rsp_data.gate !== want.gate ||
                   rsp_data.triggers_pending !== want.triggers_pending) begin
                  note_failure($sformatf("expected gate=%b pending=%b, got gate=%b pending=%b",
                                         want.gate, want.triggers_pending,
                                         rsp_data.gate, rsp_data.triggers_pending));
               end
            end
         end
         if (req_valid && req_ready) begin
            gate_forecast.push_back(advance_gate_tick(req_data));
         end
         outstanding <= gate_forecast.size();
      end
   end

endmodule

[verif/tb_top.sv]
// Top of the triac trigger testbench: clock, reset, tick stimulus, register settings and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tpat_pkg::*;

   localparam int unsigned RANDOM_TICKS = 1180;
   localparam int          STALL_LIMIT  = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    failures;
   int                    outstanding;

   int unsigned send_idle_pct = 24;
   int unsigned recv_idle_pct = 71;
   int unsigned ticks_sent = 0;
   int unsigned crossings_sent = 0;
   int unsigned settings_used = 0;
   int          quiet_cycles = 0;

   triac_phase_angle_trigger DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gate_timing_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("triac_phase_angle_trigger verification failed");
            $finish;
         end
      end
   end

   task automatic send_tick(input logic crossing, input logic [PERIOD_W-1:0] period);
      req_type item;
      item.zero_cross   = crossing;
      item.mains_period = period;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      ticks_sent++;
      if (crossing) begin
         crossings_sent++;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Stops requests, lets every response drain, then loads a full register set.
   task automatic load_settings(input cfg_type s);
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      write_reg(CSR_POS_ANGLE,   CSR_DATA_W'(s.positive_angle));
      write_reg(CSR_NEG_ANGLE,   CSR_DATA_W'(s.negative_angle));
      write_reg(CSR_OPTO_DELAY,  CSR_DATA_W'(s.opto_delay));
      write_reg(CSR_LONG_TICKS,  CSR_DATA_W'(s.long_pulse_ticks));
      write_reg(CSR_SHORT_TICKS, CSR_DATA_W'(s.short_pulse_ticks));
      write_reg(CSR_LONG_THRESH, CSR_DATA_W'(s.long_pulse_threshold));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Mostly regular mains cycles of about span ticks, with early and late
   // crossings and some unstructured requests mixed in.
   task automatic run_mains_cycles(input int unsigned span, input int unsigned len);
      int unsigned start;
      int unsigned gap;
      int unsigned r;
      start = ticks_sent;
      while (ticks_sent - start < len) begin
         r = $urandom_range(99);
         if (r < 10) begin
            send_tick(1'($urandom_range(1, 0)), PERIOD_W'($urandom));
         end else begin
            if (r < 15) begin
               send_tick(1'b1, PERIOD_W'($urandom));
            end else begin
               send_tick(1'b1, PERIOD_W'(span + $urandom_range(2, 0)));
            end
            r = $urandom_range(99);
            if (r < 80) begin
               gap = span - 1 + $urandom_range(3, 0);
            end else if (r < 92) begin
               gap = $urandom_range(span, 0);
            end else begin
               gap = $urandom_range(2 * span, span);
            end
            repeat (gap) begin
               send_tick(1'b0, PERIOD_W'($urandom));
            end
         end
      end
   endtask

   initial begin
      cfg_type     s;
      int unsigned random_sent;
      int unsigned span;
      int unsigned len;
      int unsigned first;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Both angles zero: gate stays low.
      s = '0;
      load_settings(s);
      send_tick(1'b1, 20'd100);
      send_tick(1'b0, 20'd100);

      // Both angles at 180: gate held high.
      s.positive_angle = 8'd180;
      s.negative_angle = 8'd180;
      load_settings(s);
      send_tick(1'b1, 20'd100);
      send_tick(1'b0, 20'd0);

      // Angles above 180 count as 180.
      s.positive_angle = 8'd255;
      s.negative_angle = 8'd200;
      load_settings(s);
      send_tick(1'b1, 20'd50);

      // Back to zero angles: the held gate drops at the crossing.
      s.positive_angle = 8'd0;
      s.negative_angle = 8'd0;
      load_settings(s);
      send_tick(1'b1, 20'd50);
      send_tick(1'b0, 20'd50);

      // A wide negative pulse overruns the positive fire time; the late positive
      // pulse then has zero width and never raises the gate.
      s.positive_angle       = 8'd120;
      s.negative_angle       = 8'd60;
      s.opto_delay           = 16'd0;
      s.long_pulse_ticks     = 16'd0;
      s.short_pulse_ticks    = 16'd6;
      s.long_pulse_threshold = 20'd3;
      load_settings(s);
      send_tick(1'b1, 20'd12);
      repeat (10) send_tick(1'b0, 20'd12);
      // A crossing in the middle of a running pulse cancels everything.
      send_tick(1'b1, 20'd12);
      repeat (5) send_tick(1'b0, 20'd12);
      send_tick(1'b1, 20'd12);
      send_tick(1'b0, 20'd12);

      // One angle at 180 skips that half; register and period extremes.
      s.positive_angle       = 8'd180;
      s.negative_angle       = 8'd90;
      s.opto_delay           = 16'hFFFF;
      s.long_pulse_ticks     = 16'hFFFF;
      s.short_pulse_ticks    = 16'hFFFF;
      s.long_pulse_threshold = 20'hFFFFF;
      load_settings(s);
      send_tick(1'b1, 20'hFFFFF);
      send_tick(1'b0, 20'hFFFFF);

      // Extreme widths and threshold with a short opto delay, so long pulses run.
      s.positive_angle = 8'd45;
      s.negative_angle = 8'd135;
      s.opto_delay     = 16'd0;
      load_settings(s);
      run_mains_cycles(20, 30);

      random_sent = 0;
      while (random_sent < RANDOM_TICKS) begin
         if (random_sent < RANDOM_TICKS / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 71;
         end else if (random_sent < 2 * RANDOM_TICKS / 3) begin
            send_idle_pct = 71;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         span = $urandom_range(60, 6);
         case ($urandom_range(9))
            0: s.positive_angle = 8'd0;
            1: s.positive_angle = 8'd180;
            2: s.positive_angle = 8'($urandom_range(255, 181));
            default: s.positive_angle = 8'($urandom_range(180, 1));
         endcase
         case ($urandom_range(9))
            0: s.negative_angle = 8'd0;
            1: s.negative_angle = 8'd180;
            2: s.negative_angle = 8'($urandom_range(255, 181));
            default: s.negative_angle = 8'($urandom_range(180, 1));
         endcase
         s.opto_delay = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(16, 0));
         s.long_pulse_ticks = ($urandom_range(9) == 0) ?
                              16'($urandom) : 16'($urandom_range(12, 0));
         s.short_pulse_ticks = ($urandom_range(9) == 0) ?
                               16'($urandom) : 16'($urandom_range(12, 0));
         s.long_pulse_threshold = ($urandom_range(9) == 0) ?
                                  20'($urandom) : 20'($urandom_range(span / 2 + 2, 0));
         load_settings(s);
         len = $urandom_range(110, 50);
         first = ticks_sent;
         run_mains_cycles(span, len);
         // A mains cycle can run past len, so count what was really sent.
         random_sent += ticks_sent - first;
      end

      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
      repeat (10) @(posedge clock);

      $display("Checked %0d gate ticks, %0d of them mains crossings, under %0d register settings.",
               ticks_sent, crossings_sent, settings_used);
      $display("Handshake idling ran sender-light, receiver-light and back-to-back; %0d failures.",
               failures);
      if (failures == 0 && outstanding == 0) begin
         $display("triac_phase_angle_trigger verification clean");
      end else begin
         $display("triac_phase_angle_trigger verification failed");
      end
      $finish;
   end

endmodule
